### rtl/core/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue.
// Taken in by the top level; depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by the cell and the top level; depends on nothing else.
package deq_pkg;

	localparam int unsigned WORD_W         = 64;
	localparam int unsigned DEF_CAPACITY   = 64;
	localparam int unsigned DEF_DATA_WIDTH = 64;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	// Per-cycle control broadcast to every cell of the chain.
	typedef struct packed {
		logic grow;      // tail marker moves one cell towards the back
		logic shrink;    // tail marker moves one cell towards the front
		logic shift_r;   // every word moves one cell towards the back
		logic shift_l;   // every word moves one cell towards the front
		logic load_back; // the cell just behind the tail takes the pushed word
	} cell_ctrl_t;

endpackage

### rtl/core/double_ended_queue.sv
// Bounded double-ended queue: top level built from a chain of storage cells.
// Depends on deq_pkg, deq_cell and double_ended_queue_macros.svh.
//
// The queue holds up to CAPACITY words in a row of cells, the front entry always in
// the first cell. A command is transferred at a rising edge where start is high and
// busy is low; busy never rises, so one command may be transferred on every clock.
// Its result is driven for exactly one cycle, marked by strobe. The command is first
// applied to the cells, the result registers then sample the cells as the command left
// them and strobe rises with them, and the rate is one command per cycle. The
// receiver cannot stall the result, so it must take each transfer in the cycle in
// which strobe is high. The clock rate is set by the back-word selection, an AND-OR
// over every cell's word chosen by a one-hot tail marker, which sits alone between
// the cells and the result registers. A push to a full queue or a pop from an empty
// queue changes nothing and is reported in op_error; an empty queue reports zero for
// both words.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
	parameter int unsigned CAPACITY   = deq_pkg::DEF_CAPACITY,
	parameter int unsigned DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH,
	parameter int unsigned COUNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   func,
	input  logic [deq_pkg::WORD_W-1:0]   push_word,
	output logic                         strobe,
	output logic [deq_pkg::WORD_W-1:0]   front_word,
	output logic [deq_pkg::WORD_W-1:0]   back_word,
	output logic [COUNT_W-1:0]           entry_count,
	output logic                         is_empty,
	output logic [1:0]                   op_error
);

	// Cell chain signals.
	deq_pkg::cell_ctrl_t                  ctrl;
	logic [DATA_WIDTH-1:0]                word_in;
	logic [CAPACITY-1:0][DATA_WIDTH-1:0]  cell_data;
	logic [CAPACITY-1:0][DATA_WIDTH-1:0]  cell_back;
	logic [CAPACITY-1:0]                  cell_tail;
	logic [DATA_WIDTH-1:0][CAPACITY-1:0]  back_col;
	logic [DATA_WIDTH-1:0]                back_sel;

	// Control state.
	logic [COUNT_W-1:0]   count_q;
	logic                 accept;
	logic                 empty;
	logic                 full;
	deq_pkg::func_t       op;
	deq_pkg::err_t        err;

	// First stage: the command has been applied to the cells.
	logic                 strobe_s1;
	deq_pkg::err_t        err_s1;

	// Result registers.
	logic                 strobe_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] back_q;
	logic [COUNT_W-1:0]   count_out_q;
	logic                 empty_q;
	deq_pkg::err_t        err_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign word_in = push_word[DATA_WIDTH-1:0];
	assign op      = deq_pkg::func_t'(func);
	assign empty   = (count_q == '0);
	// The queue is full exactly when the tail marker sits in the last cell.
	assign full    = cell_tail[CAPACITY-1];

	// Decode the command into the broadcast control for the cell chain. A rejected
	// command leaves every cell untouched.
	always_comb begin
		ctrl = '0;
		err  = deq_pkg::ERR_NONE;
		unique case (op)
			deq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					err = deq_pkg::ERR_FULL;
				end else begin
					ctrl.grow      = accept;
					ctrl.load_back = accept;
				end
			end
			deq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					err = deq_pkg::ERR_FULL;
				end else begin
					ctrl.grow    = accept;
					ctrl.shift_r = accept;
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					err = deq_pkg::ERR_EMPTY;
				end else begin
					ctrl.shrink  = accept;
					ctrl.shift_l = accept;
				end
			end
			deq_pkg::OP_POP_BACK: begin
				if (empty) begin
					err = deq_pkg::ERR_EMPTY;
				end else begin
					ctrl.shrink = accept;
				end
			end
			default: begin
				err = deq_pkg::ERR_NONE;
			end
		endcase
	end

	// The chain. The first cell sees the pushed word on its left and treats an
	// empty queue as a tail marker just in front of itself, so that a push into an
	// empty queue lands in the first cell. The last cell sees no marker behind it.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] d_left;
		logic [DATA_WIDTH-1:0] d_right;
		logic                  t_left;
		logic                  t_right;

		if (i == 0) begin : g_first
			assign d_left = word_in;
			assign t_left = empty;
		end else begin : g_mid_l
			assign d_left = cell_data[i-1];
			assign t_left = cell_tail[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign d_right = cell_data[i];
			assign t_right = 1'b0;
		end else begin : g_mid_r
			assign d_right = cell_data[i+1];
			assign t_right = cell_tail[i+1];
		end

		deq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_data  (word_in),
			.data_left  (d_left),
			.data_right (d_right),
			.tail_left  (t_left),
			.tail_right (t_right),
			.data       (cell_data[i]),
			.tail       (cell_tail[i]),
			.back_part  (cell_back[i])
		);

		for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_col
			assign back_col[b][i] = cell_back[i][b];
		end
	end

	// Each cell passes on its word only when it holds the tail marker, so the back
	// word is a bitwise OR across the chain; with no marker it comes out as zero.
	for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_back
		assign back_sel[b] = |back_col[b];
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.grow) begin
			count_q <= count_q + COUNT_W'(1);
		end else if (ctrl.shrink) begin
			count_q <= count_q - COUNT_W'(1);
		end
	end

	// The error code travels one stage while the cells take the command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= err;
	end

	// The result registers sample the cells as the command left them, while the
	// cells may already be taking the next command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= strobe_s1;
		end
	end

	always_ff @(posedge clk) begin
		front_q     <= empty ? '0 : cell_data[0];
		back_q      <= back_sel;
		count_out_q <= count_q;
		empty_q     <= empty;
		err_q       <= err_s1;
	end

	assign strobe      = strobe_q;
	assign front_word  = deq_pkg::WORD_W'(front_q);
	assign back_word   = deq_pkg::WORD_W'(back_q);
	assign entry_count = count_out_q;
	assign is_empty    = empty_q;
	assign op_error    = err_q;

	// The tail marker is one-hot exactly while entries are held.
	`DEQ_ASSERT_SAME(a_tail_marker, clk, arst_n, 1'b1, $onehot0(cell_tail) && ((count_q == '0) == (cell_tail == '0)))
	// Every command that reaches the first stage yields a result strobe.
	`DEQ_ASSERT_NEXT(a_result_follows, clk, arst_n, strobe_s1, strobe)
	// A rejected push is only ever reported for a queue at capacity.
	`DEQ_ASSERT_SAME(a_full_reject, clk, arst_n, strobe && (op_error == deq_pkg::ERR_FULL), entry_count == COUNT_W'(CAPACITY))
	// An empty queue reports zero for both words.
	`DEQ_ASSERT_SAME(a_empty_words, clk, arst_n, strobe && is_empty, (front_word == '0) && (back_word == '0))

endmodule

### rtl/core/deq_cell.sv
// One storage cell of the queue chain: a data word and a tail marker.
// Depends on deq_pkg for the control struct.
module deq_cell #(
	parameter int unsigned DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  deq_pkg::cell_ctrl_t     ctrl,
	input  logic [DATA_WIDTH-1:0]   push_data,
	input  logic [DATA_WIDTH-1:0]   data_left,
	input  logic [DATA_WIDTH-1:0]   data_right,
	input  logic                    tail_left,
	input  logic                    tail_right,
	output logic [DATA_WIDTH-1:0]   data,
	output logic                    tail,
	output logic [DATA_WIDTH-1:0]   back_part
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  tail_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_r) begin
			data_q <= data_left;
		end else if (ctrl.shift_l) begin
			data_q <= data_right;
		end else if (ctrl.load_back && tail_left) begin
			data_q <= push_data;
		end
	end

	// The tail marker follows its neighbour as the queue grows or shrinks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else if (ctrl.grow) begin
			tail_q <= tail_left;
		end else if (ctrl.shrink) begin
			tail_q <= tail_right;
		end
	end

	assign data      = data_q;
	assign tail      = tail_q;
	assign back_part = tail_q ? data_q : '0;

endmodule
